// File: rtl/glr_pkg.sv
// Shared types and constants for the glyph lookup text renderer.
package glr_pkg;

  localparam logic [1:0] OP_LOAD_CODE = 2'd0;
  localparam logic [1:0] OP_LOAD_ROW  = 2'd1;
  localparam logic [1:0] OP_START     = 2'd2;
  localparam logic [1:0] OP_DRAW      = 2'd3;

  localparam logic [2:0] REG_FG      = 3'd0;
  localparam logic [2:0] REG_BG      = 3'd1;
  localparam logic [2:0] REG_OPAQUE  = 3'd2;
  localparam logic [2:0] REG_THIN_W  = 3'd3;
  localparam logic [2:0] REG_THIN_H  = 3'd4;
  localparam logic [2:0] REG_WIDE_W  = 3'd5;
  localparam logic [2:0] REG_WIDE_H  = 3'd6;

  localparam logic [15:0] THIN_LIMIT = 16'd128;

  // Queued work item from front to back.
  typedef struct packed {
    logic [1:0]  opcode;
    logic        font_sel;
    logic [7:0]  slot;
    logic [15:0] code;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic [11:0] start_x;
    logic [11:0] start_y;
  } item_t;

endpackage

// File: rtl/glr_ram.sv
// Generic single-port-write, registered-read RAM.
module glr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/glr_front.sv
// Front end: accepts items into a short queue.
module glr_front #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  glr_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output glr_pkg::item_t  head
);
  localparam int AW = $clog2(DEPTH);
  glr_pkg::item_t  q_r [DEPTH];
  logic [AW-1:0]   rd_r, wr_r;
  logic [AW:0]     cnt_r;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_item;
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// File: rtl/glr_back.sv
// Back end: table loads, binary search and row emission.
module glr_back #(
  parameter int TABLE_ENTRIES    = 256,
  parameter int MAX_GLYPH_WIDTH  = 32,
  parameter int MAX_GLYPH_HEIGHT = 32,
  parameter int COORD_BITS       = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  avail,
  input  glr_pkg::item_t        item,
  output logic                  pop,
  output logic                  idle,
  input  logic [23:0]           fg_color,
  input  logic [23:0]           bg_color,
  input  logic                  opaque_mode,
  input  logic [5:0]            thin_width,
  input  logic [5:0]            thin_height,
  input  logic [5:0]            wide_width,
  input  logic [5:0]            wide_height,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] out_pos_x,
  output logic [COORD_BITS-1:0] out_pos_y,
  output logic [31:0]           out_on_bits,
  output logic [31:0]           out_paint_mask,
  output logic [23:0]           out_on_color,
  output logic [23:0]           out_off_color,
  output logic                  out_not_found,
  output logic                  out_last
);
  localparam int SW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HW  = $clog2(MAX_GLYPH_HEIGHT);
  localparam int CW  = SW + 1;
  localparam int MAXW = (MAX_GLYPH_WIDTH > 32) ? 32 : MAX_GLYPH_WIDTH;
  localparam int MAXH = (MAX_GLYPH_HEIGHT > 32) ? 32 : MAX_GLYPH_HEIGHT;

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_CMP, S_ROWRD, S_EMIT
  } state_t;

  state_t                state_r;
  logic                  thin_r;
  logic [15:0]           code_r;
  logic signed [CW:0]    lo_r, hi_r;
  logic [SW-1:0]         mid_r;
  logic [5:0]            h_r, w_r;
  logic [5:0]            row_r;
  logic [COORD_BITS-1:0] pen_x_r, pen_y_r;
  logic                  halted_r;
  logic [CW-1:0]         thin_cnt_r, wide_cnt_r;
  logic [31:0]           wmask_r;

  // code tables
  logic          code_we_t, code_we_w;
  logic [15:0]   thin_code_q, wide_code_q;
  logic [SW-1:0] code_raddr;
  logic          row_we_t, row_we_w;
  logic [SW+HW-1:0] row_waddr, row_raddr;
  logic [31:0]   thin_row_q, wide_row_q;

  logic slot_ok, row_ok, is_load;
  assign slot_ok = (32'(item.slot) < TABLE_ENTRIES);
  assign row_ok  = (32'(item.row_index) < MAX_GLYPH_HEIGHT);
  assign is_load = (state_r == S_IDLE) && avail;

  assign code_we_t = is_load && item.opcode == glr_pkg::OP_LOAD_CODE && slot_ok && !item.font_sel;
  assign code_we_w = is_load && item.opcode == glr_pkg::OP_LOAD_CODE && slot_ok && item.font_sel;
  assign row_we_t  = is_load && item.opcode == glr_pkg::OP_LOAD_ROW && slot_ok && row_ok
                     && !item.font_sel;
  assign row_we_w  = is_load && item.opcode == glr_pkg::OP_LOAD_ROW && slot_ok && row_ok
                     && item.font_sel;
  assign row_waddr = {SW'(item.slot), HW'(item.row_index)};
  assign row_raddr = {mid_r, HW'(row_r)};

  logic signed [CW:0] cnt_m1, mid_sum;
  assign mid_sum = lo_r + hi_r;
  // probe address goes to the RAM in the same cycle it is latched
  assign code_raddr = (state_r == S_PROBE) ? SW'(mid_sum >>> 1) : mid_r;

  glr_ram #(.WIDTH(16), .DEPTH(1 << SW)) u_thin_codes (
    .clk, .we(code_we_t), .waddr(SW'(item.slot)), .wdata(item.code),
    .raddr(code_raddr), .rdata(thin_code_q));
  glr_ram #(.WIDTH(16), .DEPTH(1 << SW)) u_wide_codes (
    .clk, .we(code_we_w), .waddr(SW'(item.slot)), .wdata(item.code),
    .raddr(code_raddr), .rdata(wide_code_q));
  glr_ram #(.WIDTH(32), .DEPTH(1 << (SW+HW))) u_thin_rows (
    .clk, .we(row_we_t), .waddr(row_waddr), .wdata(item.row_bits),
    .raddr(row_raddr), .rdata(thin_row_q));
  glr_ram #(.WIDTH(32), .DEPTH(1 << (SW+HW))) u_wide_rows (
    .clk, .we(row_we_w), .waddr(row_waddr), .wdata(item.row_bits),
    .raddr(row_raddr), .rdata(wide_row_q));

  function automatic logic [5:0] clamp_dim(input logic [5:0] v, input int maxv);
    if (v == 6'd0) return 6'd1;
    if (32'(v) > maxv) return 6'(maxv);
    return v;
  endfunction

  logic [15:0] probe_q;
  logic [31:0] row_q;
  logic        dthin;
  logic [5:0]  dw, dh;
  assign probe_q = thin_r ? thin_code_q : wide_code_q;
  assign row_q   = thin_r ? thin_row_q : wide_row_q;
  assign dthin   = item.code < glr_pkg::THIN_LIMIT;
  assign dw      = clamp_dim(dthin ? thin_width : wide_width, MAXW);
  assign dh      = clamp_dim(dthin ? thin_height : wide_height, MAXH);
  assign cnt_m1  = $signed({1'b0, (dthin ? thin_cnt_r : wide_cnt_r)}) - 1;

  assign pop  = is_load;
  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      thin_cnt_r <= '0;
      wide_cnt_r <= '0;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      halted_r   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (avail) begin
            if (code_we_t && {1'b0, item.slot} >= thin_cnt_r)
              thin_cnt_r <= CW'(item.slot) + 1'b1;
            if (code_we_w && {1'b0, item.slot} >= wide_cnt_r)
              wide_cnt_r <= CW'(item.slot) + 1'b1;
            if (item.opcode == glr_pkg::OP_START) begin
              pen_x_r  <= COORD_BITS'(item.start_x);
              pen_y_r  <= COORD_BITS'(item.start_y);
              halted_r <= 1'b0;
            end
            if (item.opcode == glr_pkg::OP_DRAW && !halted_r) begin
              thin_r  <= dthin;
              code_r  <= item.code;
              w_r     <= dw;
              h_r     <= dh;
              wmask_r <= (dw >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> dw);
              lo_r    <= '0;
              hi_r    <= cnt_m1;
              state_r <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (lo_r > hi_r) begin
            halted_r       <= 1'b1;
            out_valid      <= 1'b1;
            out_pos_x      <= pen_x_r;
            out_pos_y      <= pen_y_r;
            out_on_bits    <= '0;
            out_paint_mask <= '0;
            out_on_color   <= '0;
            out_off_color  <= '0;
            out_not_found  <= 1'b1;
            out_last       <= 1'b1;
            state_r        <= S_IDLE;
          end else begin
            mid_r   <= SW'(mid_sum >>> 1);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // read data for mid is valid now
          if (probe_q == code_r) begin
            row_r   <= '0;
            state_r <= S_ROWRD;
          end else begin
            if (probe_q > code_r) hi_r <= $signed({2'b00, mid_r}) - 1;
            else                  lo_r <= $signed({2'b00, mid_r}) + 1;
            state_r <= S_PROBE;
          end
        end
        S_ROWRD: state_r <= S_EMIT;
        S_EMIT: begin
          out_valid      <= 1'b1;
          out_pos_x      <= pen_x_r;
          out_pos_y      <= pen_y_r + COORD_BITS'(row_r);
          out_on_bits    <= row_q & wmask_r;
          out_paint_mask <= opaque_mode ? wmask_r : (row_q & wmask_r);
          out_on_color   <= fg_color;
          out_off_color  <= bg_color;
          out_not_found  <= 1'b0;
          out_last       <= (row_r + 6'd1 == h_r);
          if (row_r + 6'd1 == h_r) begin
            pen_x_r <= pen_x_r + COORD_BITS'(w_r);
            state_r <= S_IDLE;
          end else begin
            row_r   <= row_r + 6'd1;
            state_r <= S_ROWRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/glyph_lookup_text_renderer.sv
// Top level of the glyph lookup text renderer.
// An item is taken when start is high and busy low; a four-deep queue takes
// items while a draw runs. Loads and start items are handled in the back end's
// idle state. A draw passes the idle state, then a probe and a compare state
// per binary-search probe (at most floor(log2(count))+1 probes, plus a probe
// state to report a miss), then a row-read and an emit state per glyph row
// through the registered row RAM. Results appear on out_valid for one cycle
// each and cannot be stalled.
module glyph_lookup_text_renderer #(
  parameter int TABLE_ENTRIES    = 256,
  parameter int MAX_GLYPH_WIDTH  = 32,
  parameter int MAX_GLYPH_HEIGHT = 32,
  parameter int COORD_BITS       = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic                  in_font_sel,
  input  logic [7:0]            in_slot,
  input  logic [15:0]           in_code,
  input  logic [4:0]            in_row_index,
  input  logic [31:0]           in_row_bits,
  input  logic [11:0]           in_start_x,
  input  logic [11:0]           in_start_y,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] out_pos_x,
  output logic [COORD_BITS-1:0] out_pos_y,
  output logic [31:0]           out_on_bits,
  output logic [31:0]           out_paint_mask,
  output logic [23:0]           out_on_color,
  output logic [23:0]           out_off_color,
  output logic                  out_not_found,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  logic [23:0] fg_r, bg_r;
  logic        opq_r;
  logic [5:0]  tw_r, th_r, ww_r, wh_r;
  logic        full, not_empty, pop, idle;
  glr_pkg::item_t in_item, head;

  assign pready = 1'b1;
  assign busy   = full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 24'hFFFFFF; bg_r <= '0; opq_r <= 1'b0;
      tw_r <= 6'd8; th_r <= 6'd16; ww_r <= 6'd16; wh_r <= 6'd16;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        glr_pkg::REG_FG:     fg_r  <= pwdata[23:0];
        glr_pkg::REG_BG:     bg_r  <= pwdata[23:0];
        glr_pkg::REG_OPAQUE: opq_r <= pwdata[0];
        glr_pkg::REG_THIN_W: tw_r  <= pwdata[5:0];
        glr_pkg::REG_THIN_H: th_r  <= pwdata[5:0];
        glr_pkg::REG_WIDE_W: ww_r  <= pwdata[5:0];
        glr_pkg::REG_WIDE_H: wh_r  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      glr_pkg::REG_FG:     prdata = {8'd0, fg_r};
      glr_pkg::REG_BG:     prdata = {8'd0, bg_r};
      glr_pkg::REG_OPAQUE: prdata = {31'd0, opq_r};
      glr_pkg::REG_THIN_W: prdata = {26'd0, tw_r};
      glr_pkg::REG_THIN_H: prdata = {26'd0, th_r};
      glr_pkg::REG_WIDE_W: prdata = {26'd0, ww_r};
      glr_pkg::REG_WIDE_H: prdata = {26'd0, wh_r};
      default:             prdata = '0;
    endcase
  end

  assign in_item = '{opcode: in_opcode, font_sel: in_font_sel, slot: in_slot,
                     code: in_code, row_index: in_row_index, row_bits: in_row_bits,
                     start_x: in_start_x, start_y: in_start_y};

  glr_front #(.DEPTH(4)) u_front (
    .clk, .rst_n, .push(start && !busy), .push_item(in_item), .full,
    .pop, .not_empty, .head);

  glr_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT), .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk, .rst_n, .avail(not_empty), .item(head), .pop, .idle,
    .fg_color(fg_r), .bg_color(bg_r), .opaque_mode(opq_r),
    .thin_width(tw_r), .thin_height(th_r), .wide_width(ww_r), .wide_height(wh_r),
    .out_valid, .out_pos_x, .out_pos_y, .out_on_bits, .out_paint_mask,
    .out_on_color, .out_off_color, .out_not_found, .out_last);
endmodule

// File: rtl/glr_checker.sv
// Port-level checks for the glyph lookup text renderer, bound to the top.
module glr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_not_found,
  input logic        out_last,
  input logic [31:0] out_on_bits,
  input logic [31:0] out_paint_mask,
  input logic        pready
);
  a_nf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_found |-> out_last) else $error("error beat not last");
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_found |-> out_on_bits == 0 && out_paint_mask == 0)
    else $error("error beat has pixels");
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_on_bits & ~out_paint_mask) == 0)
    else $error("on bit outside paint mask");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> !out_valid) else $error("rows back to back");
  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind glyph_lookup_text_renderer glr_checker u_chk (
  .clk, .rst_n, .out_valid, .out_not_found, .out_last, .out_on_bits,
  .out_paint_mask, .pready);

// File: tb/glyph_row_checker.sv
// Glyph row checker: tracks the renderer's tables and pen, predicts each row and compares.
module glyph_row_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic        in_font_sel,
  input  logic [7:0]  in_slot,
  input  logic [15:0] in_code,
  input  logic [4:0]  in_row_index,
  input  logic [31:0] in_row_bits,
  input  logic [11:0] in_start_x,
  input  logic [11:0] in_start_y,
  input  logic        out_valid,
  input  logic [11:0] out_pos_x,
  input  logic [11:0] out_pos_y,
  input  logic [31:0] out_on_bits,
  input  logic [31:0] out_paint_mask,
  input  logic [23:0] out_on_color,
  input  logic [23:0] out_off_color,
  input  logic        out_not_found,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          rows_seen,
  output int          pending
);

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] on_bits;
    logic [31:0] paint;
    logic [23:0] on_color;
    logic [23:0] off_color;
    logic        not_found;
    logic        last;
  } glyph_row_t;

  glyph_row_t  rows_due[$];

  logic [15:0] code_tab [2][256];
  logic [31:0] bitmap_tab [2][8192];
  int          tab_count [2];
  logic [23:0] fg_color, bg_color;
  logic        opaque;
  logic [5:0]  glyph_w [2];
  logic [5:0]  glyph_h [2];
  logic [11:0] pen_x, pen_y;
  logic        halted;

  function automatic int clamp_dim(logic [5:0] v);
    if (v < 1) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  // Binary search over the loaded codes; -1 when the code is absent
  function automatic int find_glyph(int t, logic [15:0] c);
    int lo, hi, mid;
    lo = 0;
    hi = tab_count[t] - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (code_tab[t][mid] == c) return mid;
      if (code_tab[t][mid] > c) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  always @(posedge clk) begin : watch
    glyph_row_t got, want;
    int t, s, w, h;
    logic [31:0] wmask, on;
    if (!rst_n) begin
      rows_due.delete();
      fail_count = 0;
      rows_seen = 0;
      tab_count[0] = 0;
      tab_count[1] = 0;
      fg_color = 24'hFFFFFF;
      bg_color = '0;
      opaque = 1'b0;
      glyph_w[0] = 6'd8;
      glyph_h[0] = 6'd16;
      glyph_w[1] = 6'd16;
      glyph_h[1] = 6'd16;
      pen_x = '0;
      pen_y = '0;
      halted = 1'b0;
    end else begin
      if (out_valid) begin
        rows_seen++;
        got = '{out_pos_x, out_pos_y, out_on_bits, out_paint_mask, out_on_color,
                out_off_color, out_not_found, out_last};
        if (rows_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat x=%0d y=%0d on=%h nf=%b", $time,
                   got.x, got.y, got.on_bits, got.not_found);
        end else begin
          want = rows_due.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch expected x=%0d y=%0d on=%h paint=%h fg=%h bg=%h nf=%b last=%b",
                     $time, want.x, want.y, want.on_bits, want.paint, want.on_color,
                     want.off_color, want.not_found, want.last);
            $display("%0t:          actual x=%0d y=%0d on=%h paint=%h fg=%h bg=%h nf=%b last=%b",
                     $time, got.x, got.y, got.on_bits, got.paint, got.on_color,
                     got.off_color, got.not_found, got.last);
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          glr_pkg::REG_FG:     fg_color = pwdata[23:0];
          glr_pkg::REG_BG:     bg_color = pwdata[23:0];
          glr_pkg::REG_OPAQUE: opaque = pwdata[0];
          glr_pkg::REG_THIN_W: glyph_w[0] = pwdata[5:0];
          glr_pkg::REG_THIN_H: glyph_h[0] = pwdata[5:0];
          glr_pkg::REG_WIDE_W: glyph_w[1] = pwdata[5:0];
          glr_pkg::REG_WIDE_H: glyph_h[1] = pwdata[5:0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        case (in_opcode)
          glr_pkg::OP_LOAD_CODE: begin
            code_tab[in_font_sel][in_slot] = in_code;
            if (tab_count[in_font_sel] < in_slot + 1) tab_count[in_font_sel] = in_slot + 1;
          end
          glr_pkg::OP_LOAD_ROW:
            bitmap_tab[in_font_sel][{in_slot, in_row_index}] = in_row_bits;
          glr_pkg::OP_START: begin
            pen_x = in_start_x;
            pen_y = in_start_y;
            halted = 1'b0;
          end
          glr_pkg::OP_DRAW: if (!halted) begin
            t = (in_code < glr_pkg::THIN_LIMIT) ? 0 : 1;
            w = clamp_dim(glyph_w[t]);
            h = clamp_dim(glyph_h[t]);
            wmask = (w >= 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> w);
            s = find_glyph(t, in_code);
            if (s < 0) begin
              halted = 1'b1;
              rows_due.push_back('{pen_x, pen_y, '0, '0, '0, '0, 1'b1, 1'b1});
            end else begin
              for (int r = 0; r < h; r++) begin
                on = bitmap_tab[t][s * 32 + r] & wmask;
                rows_due.push_back('{pen_x, pen_y + 12'(r), on, opaque ? wmask : on,
                                     fg_color, bg_color, 1'b0, r == h - 1});
              end
              pen_x = pen_x + 12'(w);
            end
          end
          default: ;
        endcase
      end
    end
    pending = rows_due.size();
  end

endmodule

// File: tb/glyph_lookup_text_renderer_tb.sv
// Stimulus and verdict for the glyph lookup text renderer.
module glyph_lookup_text_renderer_tb;

  localparam int DRAIN_CYCLES = 200;
  localparam int PHASES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = '0;
  logic        in_font_sel = 1'b0;
  logic [7:0]  in_slot = '0;
  logic [15:0] in_code = '0;
  logic [4:0]  in_row_index = '0;
  logic [31:0] in_row_bits = '0;
  logic [11:0] in_start_x = '0;
  logic [11:0] in_start_y = '0;
  logic        out_valid;
  logic [11:0] out_pos_x, out_pos_y;
  logic [31:0] out_on_bits, out_paint_mask;
  logic [23:0] out_on_color, out_off_color;
  logic        out_not_found, out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, rows_seen, pending;

  // Stimulus-side view of what has been loaded, so no unwritten entry gets read
  logic [15:0] shadow_codes [2][256];
  int          shadow_count [2];
  int          rows_loaded [2][256];
  int          glyph_rows [2];
  int          items_sent;
  int          settings_used;
  bit          burst;

  always #1 clk = ~clk;

  glyph_lookup_text_renderer DUT (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_font_sel, .in_slot, .in_code, .in_row_index, .in_row_bits,
    .in_start_x, .in_start_y,
    .out_valid, .out_pos_x, .out_pos_y, .out_on_bits, .out_paint_mask,
    .out_on_color, .out_off_color, .out_not_found, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  glyph_row_checker u_checker (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_font_sel, .in_slot, .in_code, .in_row_index, .in_row_bits,
    .in_start_x, .in_start_y,
    .out_valid, .out_pos_x, .out_pos_y, .out_on_bits, .out_paint_mask,
    .out_on_color, .out_off_color, .out_not_found, .out_last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .rows_seen, .pending
  );

  initial begin
    #2_000_000;
    $display("timeout with %0d rows outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  function automatic logic [31:0] pick_bits();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [1:0] op, input logic fs, input logic [7:0] sl,
                      input logic [15:0] cd, input logic [4:0] ri, input logic [31:0] rb,
                      input logic [11:0] sx, input logic [11:0] sy);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_opcode = op;
    in_font_sel = fs;
    in_slot = sl;
    in_code = cd;
    in_row_index = ri;
    in_row_bits = rb;
    in_start_x = sx;
    in_start_y = sy;
    start = 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_regs(input logic [23:0] fg, input logic [23:0] bg, input logic op,
                          input logic [5:0] tw, input logic [5:0] th,
                          input logic [5:0] ww, input logic [5:0] wh);
    cfg_write(glr_pkg::REG_FG, {8'h00, fg});
    cfg_write(glr_pkg::REG_BG, {8'h00, bg});
    cfg_write(glr_pkg::REG_OPAQUE, {31'd0, op});
    cfg_write(glr_pkg::REG_THIN_W, {26'd0, tw});
    cfg_write(glr_pkg::REG_THIN_H, {26'd0, th});
    cfg_write(glr_pkg::REG_WIDE_W, {26'd0, ww});
    cfg_write(glr_pkg::REG_WIDE_H, {26'd0, wh});
    glyph_rows[0] = clamp_dim(int'(th));
    glyph_rows[1] = clamp_dim(int'(wh));
    settings_used++;
  endtask

  // Block may still be chewing on loads after the last row arrives
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_code(input int t, input int s, input logic [15:0] c);
    send(glr_pkg::OP_LOAD_CODE, t[0], s[7:0], c, 5'($urandom), $urandom,
         12'($urandom), 12'($urandom));
    shadow_codes[t][s] = c;
    if (shadow_count[t] < s + 1) shadow_count[t] = s + 1;
  endtask

  task automatic fill_rows(input int t, input int s);
    while (rows_loaded[t][s] < glyph_rows[t]) begin
      send(glr_pkg::OP_LOAD_ROW, t[0], s[7:0], 16'($urandom), rows_loaded[t][s][4:0],
           pick_bits(), 12'($urandom), 12'($urandom));
      rows_loaded[t][s]++;
    end
  endtask

  task automatic draw(input logic [15:0] c);
    int t;
    t = (c < glr_pkg::THIN_LIMIT) ? 0 : 1;
    for (int s = 0; s < shadow_count[t]; s++)
      if (shadow_codes[t][s] == c) fill_rows(t, s);
    send(glr_pkg::OP_DRAW, 1'($urandom), 8'($urandom), c, 5'($urandom), $urandom,
         12'($urandom), 12'($urandom));
  endtask

  task automatic pen_to(input logic [11:0] x, input logic [11:0] y);
    send(glr_pkg::OP_START, 1'($urandom), 8'($urandom), 16'($urandom), 5'($urandom),
         $urandom, x, y);
  endtask

  // Rewrites slots 0..n-1 so the searched range stays fully written
  task automatic reload(input int t, input int n, input bit sorted);
    int c;
    c = t ? 128 + $urandom_range(0, 200) : $urandom_range(0, 8);
    for (int s = 0; s < n; s++) begin
      if (!sorted) c = t ? $urandom_range(128, 65535) : $urandom_range(0, 127);
      else if (s > 0) c = c + 1 + (t ? $urandom_range(0, 200) : $urandom_range(0, 6));
      load_code(t, s, c[15:0]);
    end
  endtask

  function automatic logic [11:0] pick_coord();
    return ($urandom_range(0, 3) == 0) ? 12'(4095 - $urandom_range(0, 40)) : 12'($urandom);
  endfunction

  initial begin
    int t, n;
    logic [5:0] tw, th, ww, wh;
    items_sent = 0;
    settings_used = 0;
    burst = 1'b0;
    for (int i = 0; i < 256; i++) begin
      rows_loaded[0][i] = 0;
      rows_loaded[1][i] = 0;
    end
    shadow_count[0] = 0;
    shadow_count[1] = 0;
    glyph_rows[0] = 16;
    glyph_rows[1] = 16;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty tables, halting, pen wrap, size clamps, extreme codes
    set_regs(24'h123456, 24'hABCDEF, 1'b1, 6'd63, 6'd2, 6'd0, 6'd0);
    draw(16'd5);
    draw(16'd6);
    pen_to(12'd4095, 12'd4095);
    draw(16'hFFFF);
    pen_to(12'd0, 12'd0);
    load_code(0, 0, 16'd0);
    load_code(0, 1, 16'd64);
    load_code(0, 2, 16'd127);
    load_code(1, 0, 16'd128);
    load_code(1, 1, 16'hFFFF);
    pen_to(12'd4095, 12'd4095);
    draw(16'd0);
    draw(16'd127);
    draw(16'd64);
    draw(16'd128);
    draw(16'hFFFF);
    draw(16'd200);
    draw(16'd0);
    pen_to(12'd4000, 12'd17);
    draw(16'd1);

    // Tallest glyph with full width, then heights and widths past their range
    wait_idle();
    set_regs(24'h0F0F0F, 24'h00FF00, 1'b0, 6'd32, 6'd32, 6'd1, 6'd1);
    pen_to(12'd4090, 12'd4080);
    draw(16'd64);
    wait_idle();
    set_regs(24'hFEDCBA, 24'h010203, 1'b1, 6'd0, 6'd63, 6'd63, 6'd0);
    draw(16'd64);
    draw(16'd128);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      burst = (ph % 3 == 1);
      tw = 6'($urandom_range(1, 32));
      ww = 6'($urandom_range(1, 32));
      th = 6'($urandom_range(1, 4));
      wh = 6'($urandom_range(1, 4));
      set_regs(24'($urandom), 24'($urandom), ph[0], tw, th, ww, wh);

      n = (shadow_count[0] > 8) ? shadow_count[0] : $urandom_range(shadow_count[0], 8);
      if (ph == 2) begin
        reload(0, n, 1'b0);
        for (int s = 0; s < shadow_count[0]; s++) fill_rows(0, s);
      end else begin
        reload(0, n, 1'b1);
      end
      n = (ph == PHASES - 1) ? 24 :
          (shadow_count[1] > 6) ? shadow_count[1] : $urandom_range(shadow_count[1], 6);
      reload(1, n, 1'b1);

      pen_to(pick_coord(), pick_coord());
      for (int k = 0; k < 18; k++) begin
        case ($urandom_range(0, 19))
          0, 1: draw(16'($urandom));
          2, 3: pen_to(pick_coord(), pick_coord());
          4: begin
            t = $urandom_range(0, 1);
            send(glr_pkg::OP_LOAD_ROW, t[0], 8'($urandom_range(0, shadow_count[t] - 1)),
                 16'($urandom), 5'($urandom), pick_bits(), 12'($urandom), 12'($urandom));
          end
          default: begin
            t = $urandom_range(0, 1);
            draw(shadow_codes[t][$urandom_range(0, shadow_count[t] - 1)]);
          end
        endcase
      end
    end

    wait_idle();
    $display("%0d items sent across %0d register settings; %0d glyph rows checked",
             items_sent, settings_used, rows_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
